>>> hw/rtl/sstq_pkg.sv
// shared types and codes for the sorted timer queue
package sstq_pkg;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_ABORT = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [2:0] EV_ADDED     = 3'd0;
    localparam logic [2:0] EV_ADD_REJ   = 3'd1;
    localparam logic [2:0] EV_ABORTED   = 3'd2;
    localparam logic [2:0] EV_ABORT_REJ = 3'd3;
    localparam logic [2:0] EV_EXPIRED   = 3'd4;
    localparam logic [2:0] EV_NONE      = 3'd5;

    localparam int MAX_RESULTS = 16;
    localparam int POP_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  slot_id;
        logic [30:0] delay_ticks;
    } req_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [3:0]  event_slot;
        logic [31:0] expiry_tick;
        logic [31:0] clock_now;
        logic        last_result;
    } rsp_t;

endpackage

>>> hw/rtl/sorted_software_timer_queue_top.sv
// sorted timer queue: tick clock, slot ordering by expiry, expiry popping
// an add or abort scans the queued slots, a tick steps through the expired slots; a result may wait on m_ready
// throughput: one request at a time, the next is taken once the result is staged
// reset: synchronous active low, clears tick clock, queue count and slot flags;
// queue and expiry memories hold no reset value and need no clearing pass
module sorted_software_timer_queue_top #(
    parameter int NUM_SLOTS = 16,
    parameter int TICK_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sstq_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output sstq_pkg::rsp_t m_rsp
);
    import sstq_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int QDEPTH = 1 << SLOT_W;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [TICK_BITS-1:0] expiry;
    } qent_t;

    typedef enum logic [3:0] {
        IDLE, ADD_REJ, INS_RD, INS_CMP, ABT_RD, ABT_CMP, TICK_RD, TICK_CMP, TICK_END, EMIT
    } state_t;

    state_t               state_reg;
    logic [TICK_BITS-1:0] clock_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SLOT_W-1:0]    head_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [POP_W-1:0]     pops_reg;
    logic                 found_reg;
    logic [TICK_BITS-1:0] found_exp_reg;
    logic                 pend_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [TICK_BITS-1:0] exp_reg;
    rsp_t                 res_reg;
    logic                 m_valid_reg;
    rsp_t                 m_rsp_reg;

    qent_t                q_mem [QDEPTH];
    logic [TICK_BITS-1:0] e_mem [QDEPTH];
    qent_t                q_rdata_reg;
    logic [TICK_BITS-1:0] e_rdata_reg;

    logic                 q_we;
    logic [SLOT_W-1:0]    q_waddr;
    logic [SLOT_W-1:0]    q_raddr;
    qent_t                q_wdata;
    logic                 e_we;
    qent_t                new_ent;
    logic [SLOT_W-1:0]    in_slot;
    logic                 in_ok;
    logic                 out_free;
    logic                 out_push;
    logic [TICK_BITS-1:0] ins_diff;
    logic                 ins_later;
    logic [TICK_BITS-1:0] tick_diff;
    logic                 expired;

    assign s_ready  = (state_reg == IDLE);
    assign m_valid  = m_valid_reg;
    assign m_rsp    = m_rsp_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign out_push = out_free &&
                      ((state_reg == EMIT) || (state_reg == TICK_CMP && expired && pend_reg));

    assign in_slot = SLOT_W'(s_req.slot_id);
    assign in_ok   = int'(s_req.slot_id) < NUM_SLOTS;
    assign new_ent = '{slot: slot_reg, expiry: exp_reg};

    // queued entry later than the new one
    assign ins_diff  = q_rdata_reg.expiry - exp_reg;
    assign ins_later = (ins_diff != '0) && !ins_diff[TICK_BITS-1];
    assign tick_diff = clock_reg - q_rdata_reg.expiry;
    assign expired   = !tick_diff[TICK_BITS-1];

    always_comb begin
        q_we    = 1'b0;
        q_waddr = head_reg;
        q_wdata = q_rdata_reg;
        q_raddr = head_reg;
        e_we    = 1'b0;
        case (state_reg)
            INS_RD: begin
                q_raddr = head_reg + SLOT_W'(idx_reg - CNT_W'(1));
                if (idx_reg == '0) begin
                    q_we    = 1'b1;
                    q_wdata = new_ent;
                    e_we    = 1'b1;
                end
            end
            INS_CMP: begin
                q_we    = 1'b1;
                q_waddr = head_reg + SLOT_W'(idx_reg);
                q_wdata = ins_later ? q_rdata_reg : new_ent;
                e_we    = !ins_later;
            end
            ABT_RD: begin
                q_raddr = head_reg + SLOT_W'(idx_reg);
            end
            ABT_CMP: begin
                q_we    = found_reg;
                q_waddr = head_reg + SLOT_W'(idx_reg - CNT_W'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= q_mem[q_raddr];
        if (e_we) begin
            e_mem[slot_reg] <= exp_reg;
        end
        e_rdata_reg <= e_mem[in_slot];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            clock_reg   <= '0;
            active_reg  <= '0;
            cnt_reg     <= '0;
            head_reg    <= '0;
            pops_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_push) begin
                m_rsp_reg   <= res_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    slot_reg <= in_slot;
                    if (s_valid) begin
                        case (s_req.action)
                            ACT_ADD: begin
                                exp_reg <= clock_reg + TICK_BITS'(s_req.delay_ticks);
                                idx_reg <= cnt_reg;
                                if (!in_ok) begin
                                    res_reg   <= '{event_kind: EV_ADD_REJ,
                                                   event_slot: s_req.slot_id,
                                                   expiry_tick: '0,
                                                   clock_now: 32'(clock_reg),
                                                   last_result: 1'b1};
                                    state_reg <= EMIT;
                                end else if (active_reg[in_slot]) begin
                                    state_reg <= ADD_REJ;
                                end else begin
                                    state_reg <= INS_RD;
                                end
                            end
                            ACT_ABORT: begin
                                idx_reg   <= '0;
                                found_reg <= 1'b0;
                                if (!in_ok || !active_reg[in_slot]) begin
                                    res_reg   <= '{event_kind: EV_ABORT_REJ,
                                                   event_slot: s_req.slot_id,
                                                   expiry_tick: '0,
                                                   clock_now: 32'(clock_reg),
                                                   last_result: 1'b1};
                                    state_reg <= EMIT;
                                end else begin
                                    state_reg <= ABT_RD;
                                end
                            end
                            ACT_TICK: begin
                                clock_reg <= clock_reg + TICK_BITS'(1);
                                pops_reg  <= '0;
                                pend_reg  <= 1'b0;
                                state_reg <= TICK_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                ADD_REJ: begin
                    res_reg   <= '{event_kind: EV_ADD_REJ, event_slot: 4'(slot_reg),
                                   expiry_tick: 32'(e_rdata_reg),
                                   clock_now: 32'(clock_reg), last_result: 1'b1};
                    state_reg <= EMIT;
                end
                INS_RD: begin
                    if (idx_reg == '0) begin
                        active_reg[slot_reg] <= 1'b1;
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        res_reg   <= '{event_kind: EV_ADDED, event_slot: 4'(slot_reg),
                                       expiry_tick: 32'(exp_reg),
                                       clock_now: 32'(clock_reg), last_result: 1'b1};
                        state_reg <= EMIT;
                    end else begin
                        state_reg <= INS_CMP;
                    end
                end
                INS_CMP: begin
                    if (ins_later) begin
                        idx_reg   <= idx_reg - CNT_W'(1);
                        state_reg <= INS_RD;
                    end else begin
                        active_reg[slot_reg] <= 1'b1;
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        res_reg   <= '{event_kind: EV_ADDED, event_slot: 4'(slot_reg),
                                       expiry_tick: 32'(exp_reg),
                                       clock_now: 32'(clock_reg), last_result: 1'b1};
                        state_reg <= EMIT;
                    end
                end
                ABT_RD: begin
                    if (idx_reg == cnt_reg) begin
                        active_reg[slot_reg] <= 1'b0;
                        cnt_reg   <= cnt_reg - CNT_W'(1);
                        res_reg   <= '{event_kind: EV_ABORTED, event_slot: 4'(slot_reg),
                                       expiry_tick: 32'(found_exp_reg),
                                       clock_now: 32'(clock_reg), last_result: 1'b1};
                        state_reg <= EMIT;
                    end else begin
                        state_reg <= ABT_CMP;
                    end
                end
                ABT_CMP: begin
                    if (q_rdata_reg.slot == slot_reg) begin
                        found_reg     <= 1'b1;
                        found_exp_reg <= q_rdata_reg.expiry;
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= ABT_RD;
                end
                TICK_RD: begin
                    if (cnt_reg == '0 || pops_reg == POP_W'(MAX_RESULTS)) begin
                        state_reg <= TICK_END;
                    end else begin
                        state_reg <= TICK_CMP;
                    end
                end
                TICK_CMP: begin
                    if (!expired) begin
                        state_reg <= TICK_END;
                    end else if (!pend_reg || out_free) begin
                        res_reg   <= '{event_kind: EV_EXPIRED,
                                       event_slot: 4'(q_rdata_reg.slot),
                                       expiry_tick: 32'(q_rdata_reg.expiry),
                                       clock_now: 32'(clock_reg), last_result: 1'b0};
                        pend_reg  <= 1'b1;
                        head_reg  <= head_reg + SLOT_W'(1);
                        cnt_reg   <= cnt_reg - CNT_W'(1);
                        pops_reg  <= pops_reg + POP_W'(1);
                        active_reg[q_rdata_reg.slot] <= 1'b0;
                        state_reg <= TICK_RD;
                    end
                end
                TICK_END: begin
                    if (pend_reg) begin
                        res_reg.last_result <= 1'b1;
                    end else begin
                        res_reg <= '{event_kind: EV_NONE, event_slot: '0, expiry_tick: '0,
                                     clock_now: 32'(clock_reg), last_result: 1'b1};
                    end
                    state_reg <= EMIT;
                end
                EMIT: begin
                    if (out_free) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // queue occupancy never exceeds the slot count
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(NUM_SLOTS))
        else $error("queue count above slot count");

    // active flags agree with queue occupancy between requests
    a_active_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == IDLE |-> $countones(active_reg) == int'(cnt_reg))
        else $error("active flags disagree with queue count");

    // an abort of an active slot always finds it in the queue
    a_abort_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ABT_RD && idx_reg == cnt_reg) |-> found_reg)
        else $error("aborted slot missing from queue");

    // pops per tick stay within the result limit
    a_pop_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pops_reg <= POP_W'(MAX_RESULTS) || state_reg == IDLE)
        else $error("too many expiries in one tick");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted timer queue: directed table, then random request mix
module tb;
    import sstq_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SLOTS       = 16;
    localparam int PLAN_ROWS   = 23;
    localparam int TOTAL_ITEMS = 350;

    typedef struct packed {
        req_t req;
        logic typed;
        rsp_t want;
    } plan_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;

    logic [31:0] model_clock;
    logic [31:0] slot_due [SLOTS];
    logic        slot_busy [SLOTS];
    logic [3:0]  due_order [SLOTS];
    int          due_count;

    rsp_t        pending_events [$];
    rsp_t        want;
    plan_row_t   plan [PLAN_ROWS];
    int          errors = 0;
    int          requests_sent = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    sorted_software_timer_queue_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // sign of the wrapping difference a - b
    function automatic int tick_order(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        if (d == 32'd0) return 0;
        return d[31] ? -1 : 1;
    endfunction

    function automatic void note_event(input logic [2:0] kind, input logic [3:0] slot,
                                       input logic [31:0] due, input logic last);
        rsp_t ev;
        ev.event_kind  = kind;
        ev.event_slot  = slot;
        ev.expiry_tick = due;
        ev.clock_now   = model_clock;
        ev.last_result = last;
        pending_events.push_back(ev);
    endfunction

    function automatic void drop_from_order(input int pos);
        for (int i = pos; i + 1 < due_count; i++) due_order[i] = due_order[i + 1];
        due_count--;
    endfunction

    function automatic void predict_timer(input req_t r);
        logic [31:0] due;
        logic [3:0]  popped [MAX_RESULTS];
        int          pos;
        int          n;
        case (r.action)
            ACT_ADD: begin
                if (slot_busy[r.slot_id]) begin
                    note_event(EV_ADD_REJ, r.slot_id, slot_due[r.slot_id], 1'b1);
                end else begin
                    due = model_clock + {1'b0, r.delay_ticks};
                    pos = 0;
                    while (pos < due_count && tick_order(slot_due[due_order[pos]], due) <= 0)
                        pos++;
                    for (int i = due_count; i > pos; i--) due_order[i] = due_order[i - 1];
                    due_order[pos] = r.slot_id;
                    due_count++;
                    slot_due[r.slot_id]  = due;
                    slot_busy[r.slot_id] = 1'b1;
                    note_event(EV_ADDED, r.slot_id, due, 1'b1);
                end
            end
            ACT_ABORT: begin
                if (!slot_busy[r.slot_id]) begin
                    note_event(EV_ABORT_REJ, r.slot_id, 32'd0, 1'b1);
                end else begin
                    pos = 0;
                    while (due_order[pos] != r.slot_id) pos++;
                    drop_from_order(pos);
                    slot_busy[r.slot_id] = 1'b0;
                    note_event(EV_ABORTED, r.slot_id, slot_due[r.slot_id], 1'b1);
                end
            end
            ACT_TICK: begin
                model_clock = model_clock + 32'd1;
                n = 0;
                while (n < MAX_RESULTS && due_count > 0 &&
                       tick_order(model_clock, slot_due[due_order[0]]) >= 0) begin
                    popped[n] = due_order[0];
                    slot_busy[due_order[0]] = 1'b0;
                    drop_from_order(0);
                    n++;
                end
                if (n == 0) note_event(EV_NONE, 4'd0, 32'd0, 1'b1);
                for (int i = 0; i < n; i++)
                    note_event(EV_EXPIRED, popped[i], slot_due[popped[i]], i == n - 1);
            end
            default: ;
        endcase
    endfunction

    function automatic plan_row_t plan_row(input logic [1:0] act, input logic [3:0] slot,
                                           input logic [30:0] delay, input logic typed,
                                           input logic [2:0] kind, input logic [31:0] due,
                                           input logic [31:0] clk_now);
        plan_row_t row;
        row.req.action       = act;
        row.req.slot_id      = slot;
        row.req.delay_ticks  = delay;
        row.typed            = typed;
        row.want.event_kind  = kind;
        row.want.event_slot  = slot;
        row.want.expiry_tick = due;
        row.want.clock_now   = clk_now;
        row.want.last_result = 1'b1;
        return row;
    endfunction

    task automatic send_req(input req_t r, input logic typed, input rsp_t typed_want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        predict_timer(r);
        if (typed) begin
            void'(pending_events.pop_back());
            pending_events.push_back(typed_want);
        end
        s_req   <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (r.action != ACT_UNUSED) requests_sent++;
    endtask

    task automatic issue(input logic [1:0] act, input logic [3:0] slot, input logic [30:0] delay);
        req_t r;
        r.action      = act;
        r.slot_id     = slot;
        r.delay_ticks = delay;
        send_req(r, 1'b0, '0);
    endtask

    initial begin : stimulus
        int          pick;
        int          n;
        int          d;
        logic [3:0]  mix;
        logic [30:0] delay;

        model_clock = '0;
        due_count   = 0;
        for (int k = 0; k < SLOTS; k++) begin
            slot_busy[k] = 1'b0;
            slot_due[k]  = '0;
            due_order[k] = '0;
        end

        plan[0]  = plan_row(ACT_TICK, 4'd0, 31'd0, 1'b1, EV_NONE, 32'd0, 32'd1);
        plan[1]  = plan_row(ACT_ABORT, 4'd5, 31'd0, 1'b1, EV_ABORT_REJ, 32'd0, 32'd1);
        plan[2]  = plan_row(ACT_ADD, 4'd0, 31'd0, 1'b1, EV_ADDED, 32'd1, 32'd1);
        plan[3]  = plan_row(ACT_ADD, 4'd0, 31'd5, 1'b1, EV_ADD_REJ, 32'd1, 32'd1);
        plan[4]  = plan_row(ACT_ADD, 4'd15, 31'h7FFFFFFF, 1'b1, EV_ADDED, 32'h80000000, 32'd1);
        plan[5]  = plan_row(ACT_ADD, 4'd3, 31'd2, 1'b0, EV_ADDED, 32'd0, 32'd0);
        plan[6]  = plan_row(ACT_ADD, 4'd4, 31'd2, 1'b0, EV_ADDED, 32'd0, 32'd0);
        plan[7]  = plan_row(ACT_ADD, 4'd8, 31'd1, 1'b0, EV_ADDED, 32'd0, 32'd0);
        plan[8]  = plan_row(ACT_UNUSED, 4'd9, 31'h2AAAAAAA, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[9]  = plan_row(ACT_TICK, 4'd0, 31'd0, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[10] = plan_row(ACT_ABORT, 4'd4, 31'd0, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[11] = plan_row(ACT_ABORT, 4'd4, 31'd0, 1'b1, EV_ABORT_REJ, 32'd0, 32'd2);
        plan[12] = plan_row(ACT_TICK, 4'd0, 31'd0, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[13] = plan_row(ACT_ABORT, 4'd15, 31'd0, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[14] = plan_row(ACT_ADD, 4'd10, 31'h55555555, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[15] = plan_row(ACT_ADD, 4'd11, 31'd0, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[16] = plan_row(ACT_ADD, 4'd12, 31'd1, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[17] = plan_row(ACT_ADD, 4'd13, 31'd1, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[18] = plan_row(ACT_TICK, 4'd0, 31'd0, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[19] = plan_row(ACT_ABORT, 4'd10, 31'd0, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[20] = plan_row(ACT_TICK, 4'd0, 31'd0, 1'b1, EV_NONE, 32'd0, 32'd5);
        plan[21] = plan_row(ACT_ADD, 4'd1, 31'h40000000, 1'b0, EV_NONE, 32'd0, 32'd0);
        plan[22] = plan_row(ACT_ABORT, 4'd1, 31'd0, 1'b0, EV_NONE, 32'd0, 32'd0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++) send_req(plan[i].req, plan[i].typed, plan[i].want);

        while (requests_sent < TOTAL_ITEMS) begin
            if (requests_sent < 100) begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end else if (requests_sent < 180) begin
                src_idle_pct = 78;
                sink_stall_pct = 0;
            end else if (requests_sent < 260) begin
                src_idle_pct = 0;
                sink_stall_pct = 78;
            end else begin
                src_idle_pct = 33;
                sink_stall_pct = 33;
            end
            pick = $urandom_range(99);
            if (pick < 5) begin
                // fill every slot with one expiry so a single tick pops them all
                d = $urandom_range(0, 2);
                mix = 4'($urandom);
                for (int k = 0; k < SLOTS; k++) issue(ACT_ABORT, 4'(k), 31'($urandom));
                for (int k = 0; k < SLOTS; k++) issue(ACT_ADD, 4'(k) ^ mix, 31'(d));
                repeat (d + 2) issue(ACT_TICK, 4'($urandom), 31'($urandom));
            end else if (pick < 55) begin
                n = $urandom_range(1, 6);
                d = $urandom_range(0, 4);
                repeat (n) issue(ACT_ADD, 4'($urandom), 31'(d + $urandom_range(0, 2)));
                if ($urandom_range(1)) issue(ACT_ABORT, 4'($urandom), 31'($urandom));
                repeat (d + 3) issue(ACT_TICK, 4'($urandom), 31'($urandom));
            end else begin
                delay = $urandom_range(1) ? 31'($urandom_range(0, 40)) : 31'($urandom);
                issue(2'($urandom_range(0, 3)), 4'($urandom), delay);
            end
        end
        s_valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (errors == 0) begin
            $display("sorted_software_timer_queue_top regression: pass");
        end else begin
            $display("sorted_software_timer_queue_top regression: fail");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    $display("%0t: expected no result, got kind %0d slot %0d expiry %0h clock %0h",
                             $time, m_rsp.event_kind, m_rsp.event_slot, m_rsp.expiry_tick,
                             m_rsp.clock_now);
                    errors = errors + 1;
                end else begin
                    want = pending_events.pop_front();
                    if (m_rsp.event_kind !== want.event_kind) begin
                        $display("%0t: event_kind expected %0d got %0d",
                                 $time, want.event_kind, m_rsp.event_kind);
                        errors = errors + 1;
                    end
                    if (m_rsp.event_slot !== want.event_slot) begin
                        $display("%0t: event_slot expected %0d got %0d",
                                 $time, want.event_slot, m_rsp.event_slot);
                        errors = errors + 1;
                    end
                    if (m_rsp.expiry_tick !== want.expiry_tick) begin
                        $display("%0t: expiry_tick expected %0h got %0h",
                                 $time, want.expiry_tick, m_rsp.expiry_tick);
                        errors = errors + 1;
                    end
                    if (m_rsp.clock_now !== want.clock_now) begin
                        $display("%0t: clock_now expected %0h got %0h",
                                 $time, want.clock_now, m_rsp.clock_now);
                        errors = errors + 1;
                    end
                    if (m_rsp.last_result !== want.last_result) begin
                        $display("%0t: last_result expected %0b got %0b",
                                 $time, want.last_result, m_rsp.last_result);
                        errors = errors + 1;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin : watchdog
        #1000000;
        $display("sorted_software_timer_queue_top regression: fail");
        $finish;
    end

endmodule
